// ===== rtl/crh_pkg.sv =====
`default_nettype none
package crh_pkg;

  // field widths
  localparam int COORD_W = 32;
  localparam int DIFF_W = COORD_W + 1;
  localparam int RAD_W = 31;
  localparam int DIST_W = 31;
  localparam int SLOT_W = 4;
  localparam int CFG_W = 5;
  localparam int DEF_MAX_OBJECTS = 16;

  // datapath widths
  localparam int ACC_W = 68;
  localparam int OP_W = 66;
  localparam int DIG_W = 17;
  localparam int MUL_STEPS = 4;
  localparam int MUL_IN_W = DIG_W * MUL_STEPS;
  localparam int PROD_W = 2 * OP_W;
  localparam int ROOT_W = OP_W;
  localparam int FRAC_W = 16;
  localparam int DEN_W = OP_W;
  localparam int NUM_W = OP_W + FRAC_W;
  localparam int QBITS = DIST_W;
  localparam int ASUM_W = 64;
  localparam int R2_W = 2 * RAD_W;

  // item codes
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TRACE = 1'b1;
  localparam logic KIND_SPHERE = 1'b0;
  localparam logic KIND_PLANE = 1'b1;

  typedef struct packed {
    logic                      kind;
    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
    logic signed [COORD_W-1:0] pz;
    logic signed [COORD_W-1:0] vx;
    logic signed [COORD_W-1:0] vy;
    logic signed [COORD_W-1:0] vz;
    logic [RAD_W-1:0]          radius;
  } obj_t;

  // magnitude of a signed difference
  function automatic logic [DIFF_W-1:0] mag(input logic signed [DIFF_W-1:0] v);
    logic [DIFF_W-1:0] r;
    r = v[DIFF_W-1] ? DIFF_W'(-v) : DIFF_W'(v);
    return r;
  endfunction

  // sign extend a coordinate by one bit
  function automatic logic signed [DIFF_W-1:0] sx(input logic signed [COORD_W-1:0] v);
    logic signed [DIFF_W-1:0] r;
    r = {v[COORD_W-1], v};
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/crh_table.sv =====
`default_nettype none
module crh_table import crh_pkg::*; #(
  parameter int DEPTH = DEF_MAX_OBJECTS,
  parameter int ADDR_W = 4
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire obj_t              wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output obj_t                   rd_data
);

  obj_t mem [DEPTH];

  // object table, one write and one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/crh_mul.sv =====
`default_nettype none
module crh_mul import crh_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [OP_W-1:0]   a,
  input  wire logic [OP_W-1:0]   b,
  output logic                   done,
  output logic [PROD_W-1:0]      prod
);

  localparam int STEP_W = $clog2(MUL_STEPS + 1);

  logic                    busy;
  logic [OP_W-1:0]         a_q;
  logic [MUL_IN_W-1:0]     b_q;
  logic [STEP_W-1:0]       steps;
  logic [OP_W+DIG_W-1:0]   part;

  // one digit of b against all of a
  assign part = {{DIG_W{1'b0}}, a_q} * {{OP_W{1'b0}}, b_q[MUL_IN_W-1 -: DIG_W]};

  // digit serial multiply, top digit first
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        a_q   <= a;
        b_q   <= MUL_IN_W'(b);
        prod  <= '0;
        steps <= STEP_W'(MUL_STEPS);
        busy  <= 1'b1;
      end else if (busy) begin
        prod  <= (prod << DIG_W) + PROD_W'(part);
        b_q   <= b_q << DIG_W;
        steps <= steps - STEP_W'(1);
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  a_mul_start_idle: assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("multiply started while busy");

endmodule
`default_nettype wire

// ===== rtl/crh_sqrt.sv =====
`default_nettype none
module crh_sqrt import crh_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [PROD_W-1:0] radicand,
  output logic                   done,
  output logic [ROOT_W-1:0]      root
);

  localparam int REM_W = ROOT_W + 4;
  localparam int CNT_W = $clog2(ROOT_W + 1);

  logic              busy;
  logic [PROD_W-1:0] rad_q;
  logic [REM_W-1:0]  rem;
  logic [CNT_W-1:0]  cnt;
  logic [REM_W-1:0]  rem_sh;
  logic [REM_W-1:0]  trial;
  logic              ge;

  // restoring square root, one result bit per cycle
  assign rem_sh = {rem[ROOT_W+1:0], rad_q[PROD_W-1 -: 2]};
  assign trial = {2'b00, root, 2'b01};
  assign ge = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rad_q <= radicand;
        rem   <= '0;
        root  <= '0;
        cnt   <= CNT_W'(ROOT_W);
        busy  <= 1'b1;
      end else if (busy) begin
        rem   <= ge ? rem_sh - trial : rem_sh;
        root  <= {root[ROOT_W-2:0], ge};
        rad_q <= rad_q << 2;
        cnt   <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  a_sqrt_start_idle: assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("square root started while busy");

endmodule
`default_nettype wire

// ===== rtl/crh_div.sv =====
`default_nettype none
module crh_div import crh_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic                  done,
  output logic [QBITS-1:0]      quot
);

  localparam int REM_W = DEN_W + 1;
  localparam int CNT_W = $clog2(QBITS + 1);

  logic             busy;
  logic [DEN_W-1:0] den_q;
  logic [REM_W-1:0] rem;
  logic [QBITS-1:0] low;
  logic [CNT_W-1:0] cnt;
  logic             sat;
  logic [REM_W-1:0] rs;
  logic             ge;

  // quotient of 2^QBITS or more saturates
  assign sat = REM_W'(num[NUM_W-1:QBITS]) >= REM_W'(den);
  assign rs = {rem[DEN_W-1:0], low[QBITS-1]};
  assign ge = rs >= {1'b0, den_q};

  // restoring division over the low quotient bits only
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        den_q <= den;
        if (sat) begin
          quot <= '1;
          done <= 1'b1;
        end else begin
          rem  <= REM_W'(num[NUM_W-1:QBITS]);
          low  <= num[QBITS-1:0];
          quot <= '0;
          cnt  <= CNT_W'(QBITS);
          busy <= 1'b1;
        end
      end else if (busy) begin
        rem  <= ge ? rs - {1'b0, den_q} : rs;
        quot <= {quot[QBITS-2:0], ge};
        low  <= low << 1;
        cnt  <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  a_div_start_idle: assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("divide started while busy");

endmodule
`default_nettype wire

// ===== rtl/closest_ray_hit_search.sv =====
`default_nettype none
// Closest hit of a ray against a table of spheres and planes. A load word (command 0)
// writes one object into the table. A trace word (command 1) walks slots 0 to
// min(object_count, MAX_OBJECTS)-1 one at a time, passing over skip_slot if skip_valid
// is set, and returns one result word: the nearest hit at a ray parameter of zero or
// more, its slot and its Q15.16 distance (saturating). Only the near root of a sphere
// counts, ties keep the lowest slot. Every product goes through one shared 66x17
// multiplier in four steps, the square root is bit serial and the divide is bit serial;
// a sphere that misses early costs less. The block takes no new word until the trace
// ends, while a finished result may still wait in the output register. The user must
// write object_count only while the block is idle; the block itself does not enforce it.
module closest_ray_hit_search import crh_pkg::*; #(
  parameter int MAX_OBJECTS = DEF_MAX_OBJECTS
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [CFG_W-1:0]          object_count,
  input  wire logic                      item_valid,
  output logic                           item_stall,
  input  wire logic                      command,
  input  wire logic [SLOT_W-1:0]         slot,
  input  wire logic                      shape_kind,
  input  wire logic signed [COORD_W-1:0] point_x,
  input  wire logic signed [COORD_W-1:0] point_y,
  input  wire logic signed [COORD_W-1:0] point_z,
  input  wire logic signed [COORD_W-1:0] vector_x,
  input  wire logic signed [COORD_W-1:0] vector_y,
  input  wire logic signed [COORD_W-1:0] vector_z,
  input  wire logic [RAD_W-1:0]          radius,
  input  wire logic                      skip_valid,
  input  wire logic [SLOT_W-1:0]         skip_slot,
  output logic                           result_valid,
  input  wire logic                      result_stall,
  output logic                           hit,
  output logic [SLOT_W-1:0]              hit_slot,
  output logic [DIST_W-1:0]              hit_distance
);

  localparam int IDX_W = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1;
  localparam int CNT_W = $clog2(MAX_OBJECTS + 1);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_AIS   = 5'd1;
  localparam logic [4:0] S_AW    = 5'd2;
  localparam logic [4:0] S_NEXT  = 5'd3;
  localparam logic [4:0] S_READ  = 5'd4;
  localparam logic [4:0] S_DIS   = 5'd5;
  localparam logic [4:0] S_DW    = 5'd6;
  localparam logic [4:0] S_CHECK = 5'd7;
  localparam logic [4:0] S_SQI   = 5'd8;
  localparam logic [4:0] S_SQW   = 5'd9;
  localparam logic [4:0] S_AKI   = 5'd10;
  localparam logic [4:0] S_AKW   = 5'd11;
  localparam logic [4:0] S_CMP   = 5'd12;
  localparam logic [4:0] S_RTW   = 5'd13;
  localparam logic [4:0] S_DVI   = 5'd14;
  localparam logic [4:0] S_DVW   = 5'd15;
  localparam logic [4:0] S_CAND  = 5'd16;
  localparam logic [4:0] S_ADV   = 5'd17;
  localparam logic [4:0] S_OUT   = 5'd18;

  logic [4:0]                state;
  logic [CFG_W-1:0]          obj_count;
  logic signed [COORD_W-1:0] org_x, org_y, org_z;
  logic signed [COORD_W-1:0] dir_x, dir_y, dir_z;
  logic signed [DIFF_W-1:0]  diff_x, diff_y, diff_z;
  logic                      skip_on;
  logic [SLOT_W-1:0]         skip_idx;
  logic [CNT_W-1:0]          count;
  logic [CNT_W-1:0]          idx;
  logic [2:0]                pidx;
  logic                      neg_q;
  logic [ASUM_W-1:0]         a_sum;
  logic signed [ACC_W-1:0]   acc_h;
  logic signed [ACC_W-1:0]   acc_d;
  logic [R2_W-1:0]           r2;
  logic [OP_W-1:0]           hm;
  logic [OP_W-1:0]           kval;
  logic [PROD_W-1:0]         h2;
  logic [PROD_W-1:0]         ak;
  logic                      found;
  logic [DIST_W-1:0]         best;
  logic [IDX_W-1:0]          best_slot;
  logic [DIST_W-1:0]         cand_t;

  logic                      item_accept;
  logic                      load_out;
  logic                      tbl_wr;
  logic                      tbl_rd;
  obj_t                      wr_obj;
  obj_t                      obj;
  logic                      is_plane;
  logic [1:0]                k;
  logic signed [COORD_W-1:0] dir_k;
  logic signed [DIFF_W-1:0]  diff_k;
  logic signed [COORD_W-1:0] nrm_k;
  logic                      mul_start;
  logic [OP_W-1:0]           mul_a;
  logic [OP_W-1:0]           mul_b;
  logic                      mul_neg;
  logic                      mul_done;
  logic [PROD_W-1:0]         prod;
  logic                      sqrt_start;
  logic                      sqrt_done;
  logic [ROOT_W-1:0]         root;
  logic                      div_start;
  logic [NUM_W-1:0]          div_num;
  logic [DEN_W-1:0]          div_den;
  logic                      div_done;
  logic [QBITS-1:0]          quot;
  logic signed [ACC_W-1:0]   neg_h;
  logic signed [ACC_W-1:0]   abs_u;
  logic signed [ACC_W-1:0]   abs_v;
  logic signed [ACC_W-1:0]   term;
  logic [OP_W-1:0]           near_gap;
  logic                      skip_hit;

  assign cfg_ready = 1'b1;
  assign item_stall = (state != S_IDLE);
  assign item_accept = item_valid && !item_stall;
  assign load_out = (state == S_OUT) && (!result_valid || !result_stall);
  assign is_plane = (obj.kind == KIND_PLANE);
  assign skip_hit = skip_on && (32'(idx) == 32'(skip_idx));

  // load words with a slot inside the table go straight into it
  assign tbl_wr = item_accept && (command == CMD_LOAD) && (32'(slot) < 32'(MAX_OBJECTS));
  assign tbl_rd = (state == S_NEXT) && (idx != count) && !skip_hit;

  always_comb begin
    wr_obj.kind   = shape_kind;
    wr_obj.px     = point_x;
    wr_obj.py     = point_y;
    wr_obj.pz     = point_z;
    wr_obj.vx     = vector_x;
    wr_obj.vy     = vector_y;
    wr_obj.vz     = vector_z;
    wr_obj.radius = radius;
  end

  crh_table #(
    .DEPTH  (MAX_OBJECTS),
    .ADDR_W (IDX_W)
  ) u_table (
    .clk     (clk),
    .wr_en   (tbl_wr),
    .wr_addr (IDX_W'(slot)),
    .wr_data (wr_obj),
    .rd_en   (tbl_rd),
    .rd_addr (idx[IDX_W-1:0]),
    .rd_data (obj)
  );

  // vector component picked by the product index
  always_comb begin
    k = (pidx >= 3'd3) ? 2'(pidx - 3'd3) : 2'(pidx);
    case (k)
      2'd0: begin
        dir_k  = dir_x;
        diff_k = diff_x;
        nrm_k  = obj.vx;
      end
      2'd1: begin
        dir_k  = dir_y;
        diff_k = diff_y;
        nrm_k  = obj.vy;
      end
      default: begin
        dir_k  = dir_z;
        diff_k = diff_z;
        nrm_k  = obj.vz;
      end
    endcase
  end

  // multiplier operand select
  always_comb begin
    mul_start = 1'b0;
    mul_a = '0;
    mul_b = '0;
    mul_neg = 1'b0;
    unique case (state)
      S_AIS: begin
        mul_start = 1'b1;
        mul_a = OP_W'(mag(sx(dir_k)));
        mul_b = OP_W'(mag(sx(dir_k)));
      end
      S_DIS: begin
        mul_start = 1'b1;
        if (!is_plane) begin
          if (pidx < 3'd3) begin
            mul_a = OP_W'(mag(sx(dir_k)));
            mul_b = OP_W'(mag(diff_k));
            mul_neg = dir_k[COORD_W-1] ^ diff_k[DIFF_W-1];
          end else if (pidx < 3'd6) begin
            mul_a = OP_W'(mag(diff_k));
            mul_b = OP_W'(mag(diff_k));
          end else begin
            mul_a = OP_W'(obj.radius);
            mul_b = OP_W'(obj.radius);
          end
        end else begin
          if (pidx < 3'd3) begin
            mul_a = OP_W'(mag(diff_k));
            mul_b = OP_W'(mag(sx(nrm_k)));
            mul_neg = diff_k[DIFF_W-1] ^ nrm_k[COORD_W-1];
          end else begin
            mul_a = OP_W'(mag(sx(dir_k)));
            mul_b = OP_W'(mag(sx(nrm_k)));
            mul_neg = dir_k[COORD_W-1] ^ nrm_k[COORD_W-1];
          end
        end
      end
      S_SQI: begin
        mul_start = 1'b1;
        mul_a = hm;
        mul_b = hm;
      end
      S_AKI: begin
        mul_start = 1'b1;
        mul_a = OP_W'(a_sum);
        mul_b = kval;
      end
      default: begin
        mul_start = 1'b0;
      end
    endcase
  end

  crh_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (prod)
  );

  // signed product term for the dot products
  always_comb begin
    term = $signed({1'b0, prod[ACC_W-2:0]});
    if (neg_q) begin
      term = -term;
    end
  end

  // distance numerator and denominator
  assign neg_h = -acc_h;
  assign abs_u = acc_h[ACC_W-1] ? neg_h : acc_h;
  assign abs_v = acc_d[ACC_W-1] ? -acc_d : acc_d;
  assign near_gap = hm - root;
  assign sqrt_start = (state == S_CMP) && (h2 >= ak);
  assign div_start = (state == S_DVI);

  always_comb begin
    if (is_plane) begin
      div_num = {abs_u[OP_W-1:0], {FRAC_W{1'b0}}};
      div_den = abs_v[DEN_W-1:0];
    end else begin
      div_num = {near_gap, {FRAC_W{1'b0}}};
      div_den = DEN_W'(a_sum);
    end
  end

  crh_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sqrt_start),
    .radicand (h2 - ak),
    .done     (sqrt_done),
    .root     (root)
  );

  crh_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (quot)
  );

  // trace sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      obj_count    <= '0;
      result_valid <= 1'b0;
      found        <= 1'b0;
    end else begin
      if (cfg_valid) begin
        obj_count <= object_count;
      end

      // output register
      if (load_out) begin
        result_valid <= 1'b1;
        hit          <= found;
        hit_slot     <= found ? SLOT_W'(best_slot) : '0;
        hit_distance <= found ? best : '0;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (item_accept && (command == CMD_TRACE)) begin
            org_x    <= point_x;
            org_y    <= point_y;
            org_z    <= point_z;
            dir_x    <= vector_x;
            dir_y    <= vector_y;
            dir_z    <= vector_z;
            skip_on  <= skip_valid;
            skip_idx <= skip_slot;
            count    <= (32'(obj_count) > 32'(MAX_OBJECTS)) ? CNT_W'(MAX_OBJECTS)
                                                              : CNT_W'(obj_count);
            idx      <= '0;
            pidx     <= '0;
            a_sum    <= '0;
            found    <= 1'b0;
            state    <= S_AIS;
          end
        end
        S_AIS: begin
          state <= S_AW;
        end
        S_AW: begin
          if (mul_done) begin
            a_sum <= a_sum + prod[ASUM_W-1:0];
            pidx  <= pidx + 3'd1;
            state <= (pidx == 3'd2) ? S_NEXT : S_AIS;
          end
        end
        S_NEXT: begin
          if (idx == count) begin
            state <= S_OUT;
          end else if (skip_hit) begin
            idx <= idx + CNT_W'(1);
          end else begin
            state <= S_READ;
          end
        end
        S_READ: begin
          // sphere takes origin minus centre, plane takes point minus origin
          if (obj.kind == KIND_PLANE) begin
            diff_x <= sx(obj.px) - sx(org_x);
            diff_y <= sx(obj.py) - sx(org_y);
            diff_z <= sx(obj.pz) - sx(org_z);
          end else begin
            diff_x <= sx(org_x) - sx(obj.px);
            diff_y <= sx(org_y) - sx(obj.py);
            diff_z <= sx(org_z) - sx(obj.pz);
          end
          acc_h <= '0;
          acc_d <= '0;
          pidx  <= '0;
          state <= S_DIS;
        end
        S_DIS: begin
          neg_q <= mul_neg;
          state <= S_DW;
        end
        S_DW: begin
          if (mul_done) begin
            if (pidx < 3'd3) begin
              acc_h <= acc_h + term;
            end else if (pidx < 3'd6) begin
              acc_d <= acc_d + term;
            end else begin
              r2 <= prod[R2_W-1:0];
            end
            pidx <= pidx + 3'd1;
            if ((is_plane && pidx == 3'd5) || (!is_plane && pidx == 3'd6)) begin
              state <= S_CHECK;
            end else begin
              state <= S_DIS;
            end
          end
        end
        S_CHECK: begin
          if (!is_plane) begin
            // zero direction, origin past the centre or inside the sphere all miss
            if (a_sum == '0 || (!acc_h[ACC_W-1] && acc_h != '0)
                || acc_d[OP_W-1:0] < OP_W'(r2)) begin
              state <= S_ADV;
            end else begin
              hm    <= neg_h[OP_W-1:0];
              kval  <= acc_d[OP_W-1:0] - OP_W'(r2);
              state <= S_SQI;
            end
          end else begin
            if (acc_h == '0) begin
              cand_t <= '0;
              state  <= S_CAND;
            end else if (acc_d == '0 || acc_h[ACC_W-1] != acc_d[ACC_W-1]) begin
              state <= S_ADV;
            end else begin
              state <= S_DVI;
            end
          end
        end
        S_SQI: begin
          state <= S_SQW;
        end
        S_SQW: begin
          if (mul_done) begin
            h2    <= prod;
            state <= S_AKI;
          end
        end
        S_AKI: begin
          state <= S_AKW;
        end
        S_AKW: begin
          if (mul_done) begin
            ak    <= prod;
            state <= S_CMP;
          end
        end
        S_CMP: begin
          state <= (h2 >= ak) ? S_RTW : S_ADV;
        end
        S_RTW: begin
          if (sqrt_done) begin
            state <= S_DVI;
          end
        end
        S_DVI: begin
          state <= S_DVW;
        end
        S_DVW: begin
          if (div_done) begin
            cand_t <= quot;
            state  <= S_CAND;
          end
        end
        S_CAND: begin
          if (!found || cand_t < best) begin
            found     <= 1'b1;
            best      <= cand_t;
            best_slot <= idx[IDX_W-1:0];
          end
          state <= S_ADV;
        end
        S_ADV: begin
          idx   <= idx + CNT_W'(1);
          state <= S_NEXT;
        end
        S_OUT: begin
          if (load_out) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_miss_is_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !hit) |-> (hit_slot == '0 && hit_distance == '0))
    else $error("miss reported with nonzero slot or distance");

  a_out_waits: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && result_valid && result_stall) |=> (state == S_OUT))
    else $error("result dropped while output register full");

  a_best_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && found) |-> (32'(best_slot) < 32'(count)))
    else $error("best slot beyond the traced range");

endmodule
`default_nettype wire
